[hw/rtl/b2da_pkg.sv]
package b2da_pkg;

   typedef logic [3:0] digit_type;
   typedef logic [5:0] char_type;

   // One command per cycle to every cell of the digit row.
   typedef struct packed {
      logic clear;    // load zero
      logic convert;  // add-3 adjust, then shift one binary bit in
      logic shift;    // take the lower neighbor's digit
   } cell_ctrl_type;

   localparam char_type  ASCII_ZERO    = 6'd48;
   localparam digit_type ADJUST_LIMIT  = 4'd5;
   localparam digit_type ADJUST_AMOUNT = 4'd3;

endpackage

[hw/rtl/b2da_cell.sv]
module b2da_cell (
   input  logic                   clock,
   input  b2da_pkg::cell_ctrl_type ctrl,
   input  logic                   bit_in,
   input  b2da_pkg::digit_type    digit_low,
   output logic                   bit_out,
   output b2da_pkg::digit_type    digit_out
);

   b2da_pkg::digit_type digit_ff;
   b2da_pkg::digit_type digit_in;
   b2da_pkg::digit_type adjusted;

   // A digit of five or more overflows past nine when doubled: pre-add three.
   always_comb begin
      adjusted = (digit_ff >= b2da_pkg::ADJUST_LIMIT) ?
                 digit_ff + b2da_pkg::ADJUST_AMOUNT : digit_ff;
   end

   always_comb begin
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.convert) begin
         digit_in = {adjusted[2:0], bit_in};
      end else if (ctrl.shift) begin
         digit_in = digit_low;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign bit_out   = adjusted[3];
   assign digit_out = digit_ff;

endmodule

[hw/rtl/binary_to_decimal_ascii.sv]
// Unsigned binary to decimal ASCII converter.
// Input channel req_: one unsigned VALUE_WIDTH-bit number per transfer.
// Result channel rsp_: one ASCII digit per transfer, most significant first,
// no leading zeros; zero gives the single digit '0'. rsp_last marks the
// least significant digit of each number.
// One number is converted at a time. An item is taken at the input in idle,
// then goes through shift-and-adjust in a row of BCD digit cells (one bit per
// cycle), then the digits shift out of the top cell, one cycle per digit
// position of the row (leading zero positions included) unless rsp_ stalls.
// req_stall is high from the cycle after a transfer until the last digit is
// loaded into the output register; the next number is taken while that
// digit still waits. A stall on rsp_ holds the output register and pauses
// the digit row at the next digit to be sent. Reset returns the block to
// idle and drops any pending result.
module binary_to_decimal_ascii #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [5:0]             rsp_digit_char,
   output logic                   rsp_last
);

   localparam int NumDigits   = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int BitCntWidth = $clog2(VALUE_WIDTH + 1);
   localparam int RemWidth    = $clog2(NumDigits + 1);

   typedef enum logic [2:0] {
      StIdle    = 3'b001,
      StConvert = 3'b010,
      StEmit    = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   value_ff, value_in;
   logic [BitCntWidth-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [RemWidth-1:0]      rem_ff, rem_in;
   logic                     started_ff, started_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [5:0]               rsp_digit_char_ff;
   logic                     rsp_last_ff;

   b2da_pkg::cell_ctrl_type  cell_ctrl;
   b2da_pkg::digit_type      digits   [NumDigits];
   b2da_pkg::digit_type      shift_in [NumDigits];
   logic [NumDigits-1:0]     carry;
   b2da_pkg::digit_type      top_digit;
   logic                     out_free;
   logic                     out_load;
   logic                     final_digit;

   assign carry[0]    = value_ff[VALUE_WIDTH-1];
   assign top_digit   = digits[NumDigits-1];
   assign final_digit = (rem_ff == RemWidth'(1));

   always_comb begin
      shift_in[0] = '0;
      for (int i = 1; i < NumDigits; i++) begin
         shift_in[i] = digits[i-1];
      end
   end

   for (genvar i = 0; i < NumDigits; i++) begin : g_cell
      if (i == NumDigits - 1) begin : g_top
         b2da_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .bit_in    (carry[i]),
            .digit_low (shift_in[i]),
            .bit_out   (),
            .digit_out (digits[i])
         );
      end else begin : g_mid
         b2da_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .bit_in    (carry[i]),
            .digit_low (shift_in[i]),
            .bit_out   (carry[i+1]),
            .digit_out (digits[i])
         );
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      bit_cnt_in   = bit_cnt_ff;
      rem_in       = rem_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cell_ctrl    = '0;
      out_load     = 1'b0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               value_in        = req_value;
               bit_cnt_in      = BitCntWidth'(VALUE_WIDTH);
               cell_ctrl.clear = 1'b1;
               state_in        = StConvert;
            end
         end
         StConvert: begin
            cell_ctrl.convert = 1'b1;
            value_in          = {value_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in        = bit_cnt_ff - BitCntWidth'(1);
            if (bit_cnt_ff == BitCntWidth'(1)) begin
               rem_in     = RemWidth'(NumDigits);
               started_in = 1'b0;
               state_in   = StEmit;
            end
         end
         StEmit: begin
            if (top_digit == '0 && !started_ff && !final_digit) begin
               // drop a leading zero
               cell_ctrl.shift = 1'b1;
               rem_in          = rem_ff - RemWidth'(1);
            end else if (out_free) begin
               out_load        = 1'b1;
               rsp_valid_in    = 1'b1;
               cell_ctrl.shift = 1'b1;
               started_in      = 1'b1;
               rem_in          = rem_ff - RemWidth'(1);
               if (final_digit) begin
                  state_in = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      bit_cnt_ff <= bit_cnt_in;
      rem_ff     <= rem_in;
      started_ff <= started_in;
      if (out_load) begin
         rsp_digit_char_ff <= b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
         rsp_last_ff       <= final_digit;
      end
   end

   assign req_stall      = (state_ff != StIdle);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_digit_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
